// ===== design/lzmd_pkg.sv =====
`default_nettype none
package lzmd_pkg;

  typedef enum logic [2:0] {
    KIND_LITERAL = 3'd0,
    KIND_MATCH   = 3'd1,
    KIND_FILTER  = 3'd2,
    KIND_NONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  localparam logic [8:0]  SYM_FILTER    = 9'd256;
  localparam logic [8:0]  SYM_REPEAT    = 9'd257;
  localparam logic [8:0]  SYM_RECENT    = 9'd258;
  localparam logic [8:0]  SYM_MATCH     = 9'd262;
  localparam logic [8:0]  SYM_LAST      = 9'd305;
  localparam logic [5:0]  LEN_SYM_LAST  = 6'd43;
  localparam logic [32:0] DIST_BONUS_HI = 33'h40000;
  localparam logic [32:0] DIST_BONUS_MD = 33'h2000;
  localparam logic [32:0] DIST_BONUS_LO = 33'h100;

  typedef struct packed {
    logic [8:0]  main_symbol;
    logic [5:0]  length_symbol;
    logic [8:0]  length_extra;
    logic [5:0]  offset_symbol;
    logic [25:0] offset_extra;
    logic [3:0]  low_offset_symbol;
    logic [31:0] filter_start_delta;
    logic [31:0] filter_length;
    logic [2:0]  filter_type;
    logic [5:0]  filter_channels;
  } token_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  literal_byte;
    logic [32:0] distance;
    logic [12:0] match_length;
    logic [63:0] filter_start;
    logic [31:0] filter_size;
    logic [1:0]  filter_kind;
    logic [5:0]  channel_count;
  } result_t;

  typedef struct packed {
    logic [3:0][32:0] recent;
    logic [12:0]      last_len;
    logic [63:0]      pos;
  } hist_t;

  // length code: short codes direct, longer ones base << bits plus extra
  function automatic logic [12:0] length_from_code(input logic [5:0] s,
                                                   input logic [8:0] extra);
    logic [3:0]  nb;
    logic [12:0] base;
    logic [12:0] mask;
    nb   = s[5:2] - 4'd1;
    base = {10'd0, 1'b1, s[1:0]} << nb;
    mask = (13'd1 << nb) - 13'd1;
    if (s < 6'd8) begin
      return {7'd0, s} + 13'd2;
    end
    return base + 13'd2 + ({4'd0, extra} & mask);
  endfunction

  function automatic logic [32:0] distance_from_code(input logic [5:0]  o,
                                                     input logic [25:0] extra,
                                                     input logic [3:0]  lowsym);
    logic [4:0]  nb;
    logic [4:0]  nb_hi;
    logic [32:0] base;
    logic [26:0] mask_hi;
    logic [3:0]  mask_lo;
    logic [32:0] low;
    nb      = o[5:1] - 5'd1;
    nb_hi   = nb - 5'd4;
    base    = {31'd0, 1'b1, o[0]} << nb;
    mask_hi = (27'd1 << nb_hi) - 27'd1;
    mask_lo = (4'd1 << nb[1:0]) - 4'd1;
    if (nb >= 5'd4) begin
      low = {3'd0, extra & mask_hi[25:0], lowsym};
    end else begin
      low = {29'd0, extra[3:0] & mask_lo};
    end
    if (o < 6'd4) begin
      return {27'd0, o} + 33'd1;
    end
    return base + low + 33'd1;
  endfunction

endpackage
`default_nettype wire

// ===== design/lz_match_token_decoder_core.sv =====
`default_nettype none
// Decodes one pre-decoded LZ token per clock into a literal, match, filter,
// no-op or error beat. Tokens pass the input and then the result register;
// a new beat is taken every cycle while the result side keeps up. The four
// recent distances, last length and output position live in one register
// set updated as a token moves from the input register to the result
// register, so the throughput limit is that single decode stage.
module lz_match_token_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [8:0]  main_symbol,
  input  wire logic [5:0]  length_symbol,
  input  wire logic [8:0]  length_extra,
  input  wire logic [5:0]  offset_symbol,
  input  wire logic [25:0] offset_extra,
  input  wire logic [3:0]  low_offset_symbol,
  input  wire logic [31:0] filter_start_delta,
  input  wire logic [31:0] filter_length,
  input  wire logic [2:0]  filter_type,
  input  wire logic [5:0]  filter_channels,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [2:0]  kind,
  output      logic [7:0]  literal_byte,
  output      logic [32:0] distance,
  output      logic [12:0] match_length,
  output      logic [63:0] filter_start,
  output      logic [31:0] filter_size,
  output      logic [1:0]  filter_kind,
  output      logic [5:0]  channel_count
);
  import lzmd_pkg::*;

  token_t  tok;
  logic    tok_valid;
  result_t res;
  result_t res_next;
  hist_t   hist;
  hist_t   hist_next;
  logic    advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !tok_valid || advance;

  lzmd_decode u_decode (
    .tok       (tok),
    .hist      (hist),
    .res       (res_next),
    .hist_next (hist_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      out_valid <= 1'b0;
      hist      <= '0;
    end else begin
      if (in_ready) begin
        tok_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= tok_valid;
        if (tok_valid) begin
          hist <= hist_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok <= '{main_symbol, length_symbol, length_extra, offset_symbol,
               offset_extra, low_offset_symbol, filter_start_delta,
               filter_length, filter_type, filter_channels};
    end
    if (advance && tok_valid) begin
      res <= res_next;
    end
  end

  assign kind          = res.kind;
  assign literal_byte  = res.literal_byte;
  assign distance      = res.distance;
  assign match_length  = res.match_length;
  assign filter_start  = res.filter_start;
  assign filter_size   = res.filter_size;
  assign filter_kind   = res.filter_kind;
  assign channel_count = res.channel_count;

  // history only moves when a token is retired
  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    !(tok_valid && advance) |=> $stable(hist))
    else $error("history changed with no token retired");

  a_mtf_head: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && advance && res_next.kind == KIND_MATCH)
      |=> hist.recent[0] == $past(res_next.distance))
    else $error("match distance not at head of recent list");

  a_match_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_MATCH) |-> match_length != 13'd0)
    else $error("match beat with zero length");

  a_nonmatch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_MATCH) |-> (distance == 33'd0 && match_length == 13'd0))
    else $error("match fields set on non-match beat");

endmodule
`default_nettype wire

// ===== design/lzmd_decode.sv =====
`default_nettype none
module lzmd_decode (
  input  lzmd_pkg::token_t  tok,
  input  lzmd_pkg::hist_t   hist,
  output lzmd_pkg::result_t res,
  output lzmd_pkg::hist_t   hist_next
);
  import lzmd_pkg::*;

  logic [5:0]  sym_off;
  logic [1:0]  idx;
  logic [32:0] match_dist;
  logic [12:0] len;
  logic        is_match;

  assign sym_off = 6'(tok.main_symbol - SYM_MATCH);
  assign idx     = 2'(tok.main_symbol - SYM_RECENT);

  always_comb begin
    res        = '0;
    res.kind   = KIND_ERROR;
    hist_next  = hist;
    match_dist = '0;
    len        = '0;
    is_match   = 1'b0;

    if (tok.main_symbol < SYM_FILTER) begin
      res.kind         = KIND_LITERAL;
      res.literal_byte = tok.main_symbol[7:0];
      hist_next.pos    = hist.pos + 64'd1;
    end else if (tok.main_symbol > SYM_LAST) begin
      res.kind = KIND_ERROR;
    end else if (tok.main_symbol == SYM_FILTER) begin
      if (!tok.filter_type[2]) begin
        res.kind          = KIND_FILTER;
        res.filter_start  = hist.pos + {32'd0, tok.filter_start_delta};
        res.filter_size   = tok.filter_length;
        res.filter_kind   = tok.filter_type[1:0];
        res.channel_count = (tok.filter_type == 3'd0) ? tok.filter_channels : 6'd0;
      end
    end else if (tok.main_symbol == SYM_REPEAT) begin
      if (hist.last_len == 13'd0) begin
        res.kind = KIND_NONE;
      end else begin
        match_dist = hist.recent[0];
        len        = hist.last_len;
        is_match   = 1'b1;
      end
    end else if (tok.main_symbol < SYM_MATCH) begin
      if (tok.length_symbol <= LEN_SYM_LAST) begin
        match_dist = hist.recent[idx];
        len        = length_from_code(tok.length_symbol, tok.length_extra);
        is_match   = 1'b1;
        // move-to-front: entries above idx stay put
        for (int i = 1; i < 4; i++) begin
          if (2'(i) <= idx) begin
            hist_next.recent[i] = hist.recent[i-1];
          end
        end
        hist_next.recent[0] = match_dist;
      end
    end else begin
      match_dist = distance_from_code(tok.offset_symbol, tok.offset_extra,
                                      tok.low_offset_symbol);
      len  = length_from_code(sym_off, tok.length_extra)
           + 13'(match_dist > DIST_BONUS_HI)
           + 13'(match_dist > DIST_BONUS_MD)
           + 13'(match_dist > DIST_BONUS_LO);
      is_match = 1'b1;
      hist_next.recent = {hist.recent[2:0], match_dist};
    end

    if (is_match) begin
      res.kind           = KIND_MATCH;
      res.distance       = match_dist;
      res.match_length   = len;
      hist_next.last_len = len;
      hist_next.pos      = hist.pos + {51'd0, len};
    end
  end

endmodule
`default_nettype wire
